### rtl/uapq_pkg.sv
// uapq_pkg: shared types and codes of the unsorted array priority queue
// used by the front classifier, the job queue, the back engine and the top level
// no dependencies
package uapq_pkg;

	localparam int PRIO_W = 8;
	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	// item kind decided by the front
	localparam logic [1:0] K_INSERT = 2'd0;
	localparam logic [1:0] K_FULL   = 2'd1;
	localparam logic [1:0] K_REMOVE = 2'd2;
	localparam logic [1:0] K_EMPTY  = 2'd3;

	// command codes on the input side
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// classified item handed from front to back
	typedef struct packed {
		logic [1:0]        kind;
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] payload;
		logic [OCC_W-1:0]  occ;
	} job_t;

	// one stored queue entry
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] payload;
	} entry_t;

endpackage

### rtl/uapq_front.sv
// uapq_front: accepts items and classifies them against a shadow entry count
// depends on uapq_pkg
module uapq_front #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_cmd,
	input  logic [uapq_pkg::PRIO_W-1:0] in_prio,
	input  logic [uapq_pkg::DATA_W-1:0] in_payload,
	output logic                     push,
	output uapq_pkg::job_t           push_job,
	input  logic                     q_full
);
	import uapq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic [1:0]    kind;

	// classify the item and work out the count it leaves behind
	always_comb begin
		kind     = K_INSERT;
		cnt_next = cnt_q;
		if (in_cmd == CMD_INSERT) begin
			if (cnt_q == CW'(DEPTH)) begin
				kind = K_FULL;
			end else begin
				kind     = K_INSERT;
				cnt_next = cnt_q + CW'(1);
			end
		end else begin
			if (cnt_q == '0) begin
				kind = K_EMPTY;
			end else begin
				kind     = K_REMOVE;
				cnt_next = cnt_q - CW'(1);
			end
		end
	end

	assign in_ready         = !q_full;
	assign push             = in_valid && in_ready;
	assign push_job.kind    = kind;
	assign push_job.prio    = in_prio;
	assign push_job.payload = in_payload;
	assign push_job.occ     = OCC_W'(cnt_next);

	// shadow count runs ahead of the back engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= cnt_next;
		end
	end

endmodule

### rtl/uapq_fifo.sv
// uapq_fifo: two-entry queue of classified items between front and back
// depends on uapq_pkg
module uapq_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uapq_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output uapq_pkg::job_t pop_job
);
	import uapq_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_job   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### rtl/uapq_back.sv
// uapq_back: executes inserts and removals on the entry memory, holds the result
// depends on uapq_pkg
module uapq_back #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  uapq_pkg::job_t              job,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [uapq_pkg::DATA_W-1:0] out_payload,
	output logic [1:0]                  out_status,
	output logic [uapq_pkg::OCC_W-1:0]  out_occ
);
	import uapq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_RD_BEST = 3'd1;
	localparam logic [2:0] S_TAKE    = 3'd2;
	localparam logic [2:0] S_SCAN_RD = 3'd3;
	localparam logic [2:0] S_SCAN_WR = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	logic [2:0]        state_q;
	job_t              job_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     best_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [IW-1:0]     gap_q;
	logic [IW-1:0]     idx_q;
	logic [DATA_W-1:0] removed_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_payload_q;
	logic [1:0]        out_status_q;
	logic [OCC_W-1:0]  out_occ_q;

	logic              we;
	logic [IW-1:0]     waddr;
	entry_t            wdata;
	logic [IW-1:0]     raddr;
	logic [IW-1:0]     src_idx;
	logic              scan_last;
	logic [1:0]        status_code;

	assign pop = job_valid && (state_q == S_IDLE);

	// entries past the removed one come from one place higher
	assign src_idx   = (idx_q < gap_q) ? idx_q : idx_q + IW'(1);
	assign scan_last = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign raddr     = (state_q == S_SCAN_RD) ? src_idx : best_q;

	// write port: tail append on insert, shift down during the scan
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		if (pop && job.kind == K_INSERT) begin
			we            = 1'b1;
			waddr         = cnt_q[IW-1:0];
			wdata.prio    = job.prio;
			wdata.payload = job.payload;
		end else if (state_q == S_SCAN_WR && src_idx != idx_q) begin
			we = 1'b1;
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// status of the finished item
	always_comb begin
		case (job_q.kind)
			K_FULL:  status_code = ST_FULL;
			K_EMPTY: status_code = ST_EMPTY;
			default: status_code = ST_OK;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			job_q         <= '0;
			cnt_q         <= '0;
			best_q        <= '0;
			best_prio_q   <= '0;
			gap_q         <= '0;
			idx_q         <= '0;
			removed_q     <= '0;
			out_valid_q   <= 1'b0;
			out_payload_q <= '0;
			out_status_q  <= ST_OK;
			out_occ_q     <= '0;
		end else begin
			if (out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						job_q     <= job;
						removed_q <= '0;
						case (job.kind)
							K_INSERT: begin
								if (cnt_q == '0 || job.prio < best_prio_q) begin
									best_q      <= cnt_q[IW-1:0];
									best_prio_q <= job.prio;
								end
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_DONE;
							end
							K_REMOVE: state_q <= S_RD_BEST;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_RD_BEST: state_q <= S_TAKE;
				S_TAKE: begin
					removed_q <= rdata_q.payload;
					cnt_q     <= cnt_q - CW'(1);
					gap_q     <= best_q;
					idx_q     <= '0;
					if (cnt_q == CW'(1)) begin
						best_q  <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_WR;
				S_SCAN_WR: begin
					// strict compare keeps the earliest entry on ties
					if (idx_q == '0 || rdata_q.prio < best_prio_q) begin
						best_q      <= idx_q;
						best_prio_q <= rdata_q.prio;
					end
					if (scan_last) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_payload_q <= removed_q;
						out_status_q  <= status_code;
						out_occ_q     <= job_q.occ;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_payload = out_payload_q;
	assign out_status  = out_status_q;
	assign out_occ     = out_occ_q;

endmodule

### rtl/unsorted_array_priority_queue_top.sv
// unsorted_array_priority_queue_top: priority queue over an unsorted entry array
// depends on uapq_pkg, uapq_front, uapq_fifo, uapq_back
//
// Usage
//   Input stream s_axis: tuser is the command (0 insert, 1 remove the entry
//   with the lowest priority value, earliest stored on ties), tdata carries
//   the priority and the payload of an insert.
//   Output stream m_axis: one item per input item with the removed payload
//   (zero unless a removal succeeded), the status (ok, full, empty) and the
//   number of stored entries after the item.
//   Insert, full and empty items go from the queue to the back engine and
//   straight to its result register. A removal reads the best entry, takes
//   it, then reads and rewrites the remaining entries one at a time, a read
//   state then a write state each, while the gap is closed and the new best
//   entry is found. The back engine takes the next item only when idle.
//   A two-item queue behind the input lets the next items be taken while the
//   back engine works; the output register lets one result wait.
//   Stall: while m_axis_tready is low the finished result holds, the engine
//   waits and s_axis_tready drops once the queue fills.
//   Reset: the queue is empty, no memory clearing pass is needed.
module unsorted_array_priority_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [7:0] priority_req, [39:8] payload
	input  logic [0:0]  s_axis_tuser,  // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] removed_payload, [36:32] occupancy, rest 0
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import uapq_pkg::*;

	logic              push;
	job_t              push_job;
	logic              q_full;
	logic              pop;
	logic              pop_valid;
	job_t              pop_job;
	logic [DATA_W-1:0] out_payload;
	logic [OCC_W-1:0]  out_occ;

	// front: accept and classify
	uapq_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser[0]),
		.in_prio   (s_axis_tdata[PRIO_W-1:0]),
		.in_payload(s_axis_tdata[PRIO_W+DATA_W-1:PRIO_W]),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	// queue between front and back
	uapq_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_job  (pop_job)
	);

	// back: entry memory and result register
	uapq_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (pop_valid),
		.job        (pop_job),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_payload(out_payload),
		.out_status (m_axis_tuser),
		.out_occ    (out_occ)
	);

	assign m_axis_tdata = {3'b000, out_occ, out_payload};

	// an empty removal returns no data
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[31:0] == 32'd0)
		else $error("empty removal returned data");

	// an empty removal leaves nothing stored
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[36:32] == 5'd0)
		else $error("empty status with entries stored");

	// a rejected insert only happens at full depth
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_FULL |-> m_axis_tdata[36:32] == OCC_W'(DEPTH))
		else $error("full status below depth");

	// front stalls only when the queue to the back is full
	a_ready_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_full && !pop_valid == 1'b0)
		else $error("input stalled with room in queue");

endmodule
